FILE: rtl/lms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lms_pkg;

	// store geometry
	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SORT   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_RUN,
		S_RD,
		S_WR,
		S_EMIT_RD,
		S_EMIT_WR
	} lms_state_t;

	// one result transaction
	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     last;
		logic [1:0]               status;
		logic [CNT_W-1:0]         count;
	} lms_res_t;

endpackage

`default_nettype wire

FILE: rtl/lms_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lms_in_if
	import lms_pkg::*;
	;
	logic                     valid;
	logic                     ready;
	logic [1:0]               command;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/lms_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lms_out_if
	import lms_pkg::*;
	;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     last;
	logic [1:0]               status;
	logic [CNT_W-1:0]         count;

	modport source (output valid, output sorted_value, output last, output status,
		output count, input ready);
	modport sink (input valid, input sorted_value, input last, input status,
		input count, output ready);
endinterface

`default_nettype wire

FILE: rtl/lms_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lms_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 6
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr_a,
	input  wire logic [ADDR_W-1:0] raddr_b,
	output logic      [DATA_W-1:0] rdata_a,
	output logic      [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// one write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

FILE: rtl/lms_core.sv
`timescale 1ns / 1ps
`default_nettype none

module lms_core
	import lms_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               in_command,
	input  wire logic signed [DATA_W-1:0] in_value,
	input  wire logic [CNT_W-1:0]         capacity,
	output logic                          res_valid,
	input  wire logic                     res_ready,
	output lms_res_t                      res
);

	lms_state_t state_q, state_d;

	logic [CNT_W-1:0] count_q;
	logic             bank_q;
	logic [CNT_W-1:0] width_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] mid_q;
	logic [CNT_W-1:0] hi_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] k_q;

	logic             in_acc;
	logic [CNT_W-1:0] cap_eff;
	logic             is_full;
	logic             ins_wr;
	logic             mrg_wr;
	logic [CNT_W-1:0] lo_w;
	logic [CNT_W-1:0] lo_2w;
	logic [CNT_W-1:0] width2;
	logic [CNT_W-1:0] mid_c;
	logic [CNT_W-1:0] hi_c;
	logic [CNT_W-1:0] k_inc;
	logic             run_end;
	logic             pass_end;
	logic             sort_done;
	logic             take_left;
	logic             emit_last;

	logic [ADDR_W-1:0] waddr;
	logic [DATA_W-1:0] wdata;
	logic [ADDR_W-1:0] raddr_a;
	logic [ADDR_W-1:0] raddr_b;
	logic [DATA_W-1:0] r0_a, r0_b, r1_a, r1_b;
	logic [DATA_W-1:0] src_a, src_b;

	// two banks, one holds the current data, the other takes a merge pass
	lms_ram #(.DATA_W(DATA_W), .ADDR_W(ADDR_W)) u_bank0 (
		.clk(clk), .we((ins_wr && !bank_q) || (mrg_wr && bank_q)),
		.waddr(waddr), .wdata(wdata), .raddr_a(raddr_a), .raddr_b(raddr_b),
		.rdata_a(r0_a), .rdata_b(r0_b)
	);

	lms_ram #(.DATA_W(DATA_W), .ADDR_W(ADDR_W)) u_bank1 (
		.clk(clk), .we((ins_wr && bank_q) || (mrg_wr && !bank_q)),
		.waddr(waddr), .wdata(wdata), .raddr_a(raddr_a), .raddr_b(raddr_b),
		.rdata_a(r1_a), .rdata_b(r1_b)
	);

	// run bounds and merge decision
	always_comb begin
		in_acc    = in_valid && in_ready;
		cap_eff   = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;
		is_full   = count_q >= cap_eff;
		src_a     = bank_q ? r1_a : r0_a;
		src_b     = bank_q ? r1_b : r0_b;
		lo_w      = lo_q + width_q;
		width2    = width_q << 1;
		lo_2w     = lo_q + width2;
		mid_c     = (lo_w >= count_q) ? count_q : lo_w;
		hi_c      = (lo_2w >= count_q) ? count_q : lo_2w;
		k_inc     = k_q + 1'b1;
		run_end   = k_inc == hi_q;
		pass_end  = lo_2w >= count_q;
		sort_done = width2 >= count_q;
		emit_last = k_inc == count_q;
		take_left = (j_q >= hi_q) ||
			((i_q < mid_q) && ($signed(src_a) <= $signed(src_b)));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && in_command == CMD_SORT && count_q != '0) begin
					state_d = (count_q == CNT_W'(1)) ? S_EMIT_RD : S_RUN;
				end
			end
			S_RUN: state_d = S_RD;
			S_RD:  state_d = S_WR;
			S_WR: begin
				if (!run_end) begin
					state_d = S_RD;
				end else if (pass_end && sort_done) begin
					state_d = S_EMIT_RD;
				end else begin
					state_d = S_RUN;
				end
			end
			S_EMIT_RD: state_d = S_EMIT_WR;
			S_EMIT_WR: begin
				if (res_ready) begin
					state_d = emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs, memory controls and results
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		res       = '{sorted_value: '0, last: 1'b1, status: STAT_OK, count: count_q};
		ins_wr    = 1'b0;
		mrg_wr    = 1'b0;
		waddr     = k_q[ADDR_W-1:0];
		wdata     = take_left ? src_a : src_b;
		raddr_a   = i_q[ADDR_W-1:0];
		raddr_b   = j_q[ADDR_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				in_ready = res_ready;
				if (in_acc) begin
					case (in_command)
						CMD_INSERT: begin
							res_valid = 1'b1;
							if (is_full) begin
								res.status = STAT_FULL;
							end else begin
								ins_wr    = 1'b1;
								waddr     = count_q[ADDR_W-1:0];
								wdata     = in_value;
								res.count = count_q + 1'b1;
							end
						end
						CMD_SORT: begin
							if (count_q == '0) begin
								res_valid  = 1'b1;
								res.status = STAT_EMPTY;
							end
						end
						CMD_CLEAR: begin
							res_valid = 1'b1;
							res.count = '0;
						end
						default: res_valid = 1'b1;
					endcase
				end
			end
			S_RUN, S_RD: begin
			end
			S_WR: mrg_wr = 1'b1;
			S_EMIT_RD, S_EMIT_WR: begin
				raddr_a = k_q[ADDR_W-1:0];
				if (state_q == S_EMIT_WR) begin
					res_valid        = res_ready;
					res.sorted_value = src_a;
					res.last         = emit_last;
				end
			end
			default: begin
			end
		endcase
	end

	// state, count and bank select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			bank_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ins_wr) begin
				count_q <= count_q + 1'b1;
			end else if (in_acc && in_command == CMD_CLEAR) begin
				count_q <= '0;
			end
			if (state_q == S_WR && run_end && pass_end) begin
				bank_q <= !bank_q;
			end
		end
	end

	// merge indexes
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				width_q <= CNT_W'(1);
				lo_q    <= '0;
				k_q     <= '0;
			end
			S_RUN: begin
				mid_q <= mid_c;
				hi_q  <= hi_c;
				i_q   <= lo_q;
				j_q   <= mid_c;
				k_q   <= lo_q;
			end
			S_WR: begin
				k_q <= k_inc;
				if (take_left) begin
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
				if (run_end) begin
					if (pass_end) begin
						lo_q    <= '0;
						width_q <= width2;
						k_q     <= '0;
					end else begin
						lo_q <= lo_2w;
					end
				end
			end
			S_EMIT_WR: begin
				if (res_ready) begin
					k_q <= k_inc;
				end
			end
			default: begin
			end
		endcase
	end

	// merge writes stay inside the current run
	a_wr_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR |-> (k_q < hi_q && i_q <= mid_q && j_q <= hi_q))
		else $error("merge write outside its run");

	// a result is only pushed into a free output slot
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_ready)
		else $error("result pushed while output full");

	// held count never passes the store depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("held count beyond depth");

	// count stays fixed through a sort
	a_count_sort: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && $past(state_q) != S_IDLE) |-> $stable(count_q))
		else $error("count changed during sort");

endmodule

`default_nettype wire

FILE: rtl/load_and_merge_sort.sv
`timescale 1ns / 1ps
`default_nettype none

// channel    dir  handshake      payload
// in_ch      in   valid/ready    command[1:0], value[31:0] signed
// out_ch     out  valid/ready    sorted_value[31:0] signed, last, status[1:0], count[6:0]
// cfg        in   cfg_we         cfg_wdata[6:0] capacity_limit
//
// insert, clear and unused codes each give one result in idle; a two-entry result
// queue keeps inserts at one per cycle while results drain; input stalls when it is full.
// a sort of n values takes ceil(log2 n) merge passes, each run opened by a setup state,
// then emission: the read-compare-write loop on the registered RAM read.
// arst_n clears the count, the bank select, the queue and sets the capacity to 64.
// a stalled output holds the sort at its next emission; input waits until done.

module load_and_merge_sort
	import lms_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	lms_in_if.sink                in_ch,
	lms_out_if.source             out_ch,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata
);

	logic [CNT_W-1:0] cap_q;
	logic             res_valid;
	logic             res_ready;
	lms_res_t         res;
	lms_res_t         buf_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic             pop;
	lms_res_t         head;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CNT_W'(DEPTH);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	lms_core u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_command(in_ch.command), .in_value(in_ch.value),
		.capacity(cap_q),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	// two-entry result queue
	assign res_ready = fill_q != 2'd2;
	assign pop       = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, res_valid} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			buf_q[wr_ptr_q] <= res;
		end
	end

	// queue head drives the output transaction
	assign head                = buf_q[rd_ptr_q];
	assign out_ch.valid        = fill_q != '0;
	assign out_ch.sorted_value = head.sorted_value;
	assign out_ch.last         = head.last;
	assign out_ch.status       = head.status;
	assign out_ch.count        = head.count;

endmodule

`default_nettype wire
